>>> rtl/scan_segment_overwrite_macros.svh
// Assertion macros shared by the scan segment overwrite RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef SCAN_SEGMENT_OVERWRITE_MACROS_SVH
`define SCAN_SEGMENT_OVERWRITE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SSO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SSO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sso_pkg.sv
// Shared types, codes and constants of the scan segment overwrite block.
// No dependencies; used by sso_div, sso_geom and scan_segment_overwrite.
`timescale 1ns / 1ps

package sso_pkg;

  localparam int SCAN_DEPTH_DEF = 1024;
  localparam int IDX_W          = 13;   // holds any bin index up to 4096
  localparam int DIV_W          = 16;
  localparam int CORDIC_STEPS   = 14;
  localparam int SQRT_STEPS     = 16;
  localparam int CX_W           = 28;

  // Commands on the input stream.
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_SEG  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ANGLE_START = 2'd0;
  localparam logic [1:0] CFG_ANGLE_STEP  = 2'd1;
  localparam logic [1:0] CFG_SCAN_LENGTH = 2'd2;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] z;
  } point_t;

  typedef struct packed {
    logic             done;
    logic [1:0][15:0] radius;
    logic [1:0][15:0] ang;
  } geom_rsp_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

  // Rotation angles round(atan(2^-i) * 8192), radians Q2.13.
  function automatic logic [12:0] atan_lut(input logic [3:0] i);
    logic [12:0] v;
    case (i)
      4'd0:    v = 13'd6434;
      4'd1:    v = 13'd3798;
      4'd2:    v = 13'd2007;
      4'd3:    v = 13'd1019;
      4'd4:    v = 13'd511;
      4'd5:    v = 13'd256;
      4'd6:    v = 13'd128;
      4'd7:    v = 13'd64;
      4'd8:    v = 13'd32;
      4'd9:    v = 13'd16;
      4'd10:   v = 13'd8;
      4'd11:   v = 13'd4;
      4'd12:   v = 13'd2;
      4'd13:   v = 13'd1;
      default: v = 13'd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/scan_segment_overwrite.sv
// Top level of the scan segment overwrite block: range memory, command
// sequencer and segment writer. Depends on sso_pkg, sso_geom and sso_div.
//
//   channel  | direction | contents
//   in_      | request   | tuser: command; tdata: bin, range, start x/z, end x/z
//   out_     | result    | tuser: range valid; tdata: bin, range (read only)
//   cfg_     | write     | angle_start, angle_step, scan_length
//
// A load in range writes the memory when accepted. A read result is registered in
// the memory output register, then in the output register or, while that stalls, in
// the hold register; one waiting result plus one in the hold register may stand.
// A segment runs through the geometry unit, up to three divisions in the shared
// divider, then steps through its bins, writing each in use, and a closing step.
// The range memory has no reset; rst_n clears control state only. Requests are
// held off while a segment runs, in the cycle after a read, or while two results wait.
`timescale 1ns / 1ps
`include "scan_segment_overwrite_macros.svh"

module scan_segment_overwrite #(
  parameter int SCAN_DEPTH = sso_pkg::SCAN_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // bin_index[9:0], range_in[25:10], start_x[41:26], start_z[57:42],
  // end_x[73:58], end_z[89:74], zero fill
  input  logic [95:0] in_tdata,
  // command[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // bin_out[9:0], range_out[25:10], zero fill
  output logic [31:0] out_tdata,
  // range_valid[0]
  output logic [0:0]  out_tuser,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import sso_pkg::*;

  localparam int AW = $clog2(SCAN_DEPTH);
  localparam logic [IDX_W-1:0] DEPTH_I = IDX_W'(SCAN_DEPTH);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_GEOM  = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_WRITE = 2'd3;

  localparam logic [1:0] DSEL_CNT = 2'd0;
  localparam logic [1:0] DSEL_BIN = 2'd1;
  localparam logic [1:0] DSEL_DEC = 2'd2;

  // Request fields.
  logic [1:0]  cmd;
  logic [9:0]  req_bin;
  logic [15:0] req_range;
  logic [15:0] sx, sz, ex, ez;
  assign cmd       = in_tuser;
  assign req_bin   = in_tdata[9:0];
  assign req_range = in_tdata[25:10];
  assign sx        = in_tdata[41:26];
  assign sz        = in_tdata[57:42];
  assign ex        = in_tdata[73:58];
  assign ez        = in_tdata[89:74];

  // Configuration registers.
  logic [15:0] angle_start_r;
  logic [13:0] angle_step_r;
  logic [10:0] scan_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_start_r <= 16'h9B78;   // -25736
      angle_step_r  <= 14'd29;
      scan_length_r <= 11'd1024;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ANGLE_START: angle_start_r <= cfg_wdata;
        CFG_ANGLE_STEP:  angle_step_r  <= cfg_wdata[13:0];
        CFG_SCAN_LENGTH: scan_length_r <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  // Control and datapath registers.
  logic [1:0]       state_r, state_nxt;
  logic [1:0]       dsel_r, dsel_nxt;
  logic             div_start_r, div_start_nxt;
  logic [DIV_W-1:0] div_dvd_r, div_dvd_nxt;
  logic [DIV_W-1:0] div_dvs_r, div_dvs_nxt;
  logic [15:0]      ds_r, ds_nxt;
  logic             dneg_r, dneg_nxt;
  logic [15:0]      dmag_r, dmag_nxt;
  logic             n0neg_r, n0neg_nxt;
  logic [15:0]      n0mag_r, n0mag_nxt;
  logic [15:0]      cnt_r, cnt_nxt;
  logic [15:0]      i_r, i_nxt;
  logic [16:0]      q_r, q_nxt;
  logic [16:0]      r_r, r_nxt;
  logic [15:0]      qd_r, qd_nxt;
  logic [15:0]      rd_r, rd_nxt;
  logic [18:0]      k_r, k_nxt;
  logic             nz_r, nz_nxt;

  logic             rd_pend_r;
  logic             rd_oob_r;
  logic [9:0]       rd_bin_r;
  logic             out_valid_r;
  logic [9:0]       out_bin_r;
  logic [15:0]      out_rng_r;
  logic             out_vld_r;
  logic             hold_valid_r;
  logic [9:0]       hold_bin_r;
  logic [15:0]      hold_rng_r;
  logic             hold_vld_r;

  // Range memory: bit 16 valid, bits 15..0 range.
  logic [16:0]      mem [SCAN_DEPTH];
  logic [16:0]      mem_q_r;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [16:0]      mem_wd;
  logic             mem_re;

  logic             accept;
  logic [IDX_W-1:0] req_idx;
  logic             req_in_depth;
  logic             seg_skip;
  logic             geom_start;
  point_t           pts [2];
  geom_rsp_t        geom_rsp;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  logic [IDX_W-1:0] limit;
  logic             k_neg;
  logic             bin_ok;
  logic [IDX_W-1:0] wbin;
  logic [16:0]      wval;
  logic             seg_we;
  logic [16:0]      r_sum;

  logic [16:0]      diff17, diff_mag;
  logic [17:0]      n0_18, n0_mag;
  logic [16:0]      d17, d_mag;
  logic [18:0]      q19;

  assign in_tready    = (state_r == S_IDLE) && !rd_pend_r && !hold_valid_r;
  assign accept       = in_tvalid && in_tready;
  assign req_idx      = IDX_W'(req_bin);
  assign req_in_depth = req_idx < DEPTH_I;
  assign seg_skip     = sz[15] || (sz == 16'd0) || ez[15] || (ez == 16'd0) ||
                        (angle_step_r == 14'd0);
  assign geom_start   = accept && (cmd == CMD_SEG) && !seg_skip;
  assign pts[0]       = '{x: sx, z: sz};
  assign pts[1]       = '{x: ex, z: ez};

  sso_geom u_geom (
    .clk   (clk),
    .rst_n (rst_n),
    .start (geom_start),
    .pts   (pts),
    .rsp   (geom_rsp)
  );

  assign div_req.start    = div_start_r;
  assign div_req.dividend = div_dvd_r;
  assign div_req.divisor  = div_dvs_r;

  sso_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Segment write step: bin from the running floor quotient k, value from
  // the running interpolation offset q.
  always_comb begin
    limit  = (IDX_W'(scan_length_r) < DEPTH_I) ? IDX_W'(scan_length_r) : DEPTH_I;
    k_neg  = k_r[18];
    bin_ok = (!k_neg && (k_r[17:0] < 18'(limit))) ||
             ((k_r == '1) && nz_r && (limit != '0));
    wbin   = k_neg ? '0 : k_r[IDX_W-1:0];
    wval   = dneg_r ? ({1'b0, ds_r} + q_r) : ({1'b0, ds_r} - q_r);
    seg_we = (state_r == S_WRITE) && (i_r != cnt_r) && bin_ok;
    r_sum  = r_r + {1'b0, rd_r};
  end

  // Memory port selection.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = req_idx[AW-1:0];
    mem_wd = (req_range != 16'd0) ? {1'b1, req_range} : 17'd0;
    mem_re = accept && (cmd == CMD_READ);
    if (accept && (cmd == CMD_LOAD) && req_in_depth) begin
      mem_we = 1'b1;
    end else if (seg_we) begin
      mem_we = 1'b1;
      mem_wa = wbin[AW-1:0];
      mem_wd = {1'b1, wval[15:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) mem_q_r <= mem[req_idx[AW-1:0]];
  end

  // Segment sequencer.
  always_comb begin
    state_nxt     = state_r;
    dsel_nxt      = dsel_r;
    div_start_nxt = 1'b0;
    div_dvd_nxt   = div_dvd_r;
    div_dvs_nxt   = div_dvs_r;
    ds_nxt        = ds_r;
    dneg_nxt      = dneg_r;
    dmag_nxt      = dmag_r;
    n0neg_nxt     = n0neg_r;
    n0mag_nxt     = n0mag_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    q_nxt         = q_r;
    r_nxt         = r_r;
    qd_nxt        = qd_r;
    rd_nxt        = rd_r;
    k_nxt         = k_r;
    nz_nxt        = nz_r;

    diff17   = {geom_rsp.ang[0][15], geom_rsp.ang[0]} -
               {geom_rsp.ang[1][15], geom_rsp.ang[1]};
    diff_mag = diff17[16] ? (17'd0 - diff17) : diff17;
    n0_18    = {{2{geom_rsp.ang[0][15]}}, geom_rsp.ang[0]} -
               {{2{angle_start_r[15]}}, angle_start_r};
    n0_mag   = n0_18[17] ? (18'd0 - n0_18) : n0_18;
    d17      = {1'b0, geom_rsp.radius[0]} - {1'b0, geom_rsp.radius[1]};
    d_mag    = d17[16] ? (17'd0 - d17) : d17;
    q19      = {3'b000, div_rsp.quot};

    unique case (state_r)
      S_IDLE: begin
        if (geom_start) state_nxt = S_GEOM;
      end
      S_GEOM: begin
        if (geom_rsp.done) begin
          ds_nxt        = geom_rsp.radius[0];
          dneg_nxt      = d17[16];
          dmag_nxt      = d_mag[15:0];
          n0neg_nxt     = n0_18[17];
          n0mag_nxt     = n0_mag[15:0];
          div_dvd_nxt   = diff_mag[15:0];
          div_dvs_nxt   = {2'b00, angle_step_r};
          div_start_nxt = 1'b1;
          dsel_nxt      = DSEL_CNT;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          unique case (dsel_r)
            DSEL_CNT: begin
              cnt_nxt = div_rsp.quot;
              if (div_rsp.quot == '0) begin
                state_nxt = S_IDLE;
              end else begin
                div_dvd_nxt   = n0mag_r;
                div_dvs_nxt   = {2'b00, angle_step_r};
                div_start_nxt = 1'b1;
                dsel_nxt      = DSEL_BIN;
              end
            end
            DSEL_BIN: begin
              nz_nxt        = div_rsp.rem != '0;
              k_nxt         = n0neg_r ?
                              (19'd0 - q19 - {18'd0, (div_rsp.rem != '0)}) : q19;
              div_dvd_nxt   = dmag_r;
              div_dvs_nxt   = cnt_r;
              div_start_nxt = 1'b1;
              dsel_nxt      = DSEL_DEC;
            end
            DSEL_DEC: begin
              qd_nxt    = div_rsp.quot;
              rd_nxt    = div_rsp.rem;
              q_nxt     = '0;
              r_nxt     = '0;
              i_nxt     = '0;
              state_nxt = S_WRITE;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_WRITE: begin
        if (i_r == cnt_r) begin
          state_nxt = S_IDLE;
        end else begin
          i_nxt = i_r + 1'b1;
          k_nxt = k_r - 19'd1;
          if (r_sum >= {1'b0, cnt_r}) begin
            r_nxt = r_sum - {1'b0, cnt_r};
            q_nxt = q_r + {1'b0, qd_r} + 17'd1;
          end else begin
            r_nxt = r_sum;
            q_nxt = q_r + {1'b0, qd_r};
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dsel_r      <= DSEL_CNT;
      div_start_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dsel_r      <= dsel_nxt;
      div_start_r <= div_start_nxt;
    end
    div_dvd_r <= div_dvd_nxt;
    div_dvs_r <= div_dvs_nxt;
    ds_r      <= ds_nxt;
    dneg_r    <= dneg_nxt;
    dmag_r    <= dmag_nxt;
    n0neg_r   <= n0neg_nxt;
    n0mag_r   <= n0mag_nxt;
    cnt_r     <= cnt_nxt;
    i_r       <= i_nxt;
    q_r       <= q_nxt;
    r_r       <= r_nxt;
    qd_r      <= qd_nxt;
    rd_r      <= rd_nxt;
    k_r       <= k_nxt;
    nz_r      <= nz_nxt;
  end

  // Read results: output register with one hold register behind it.
  logic        taken;
  logic        ent_vld;
  logic [15:0] ent_rng;
  assign taken   = out_valid_r && out_tready;
  assign ent_vld = mem_q_r[16] && !rd_oob_r;
  assign ent_rng = ent_vld ? mem_q_r[15:0] : 16'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
    end else begin
      rd_pend_r <= mem_re;
      if (rd_pend_r) begin
        if (!out_valid_r || taken) begin
          out_valid_r <= 1'b1;
        end else begin
          hold_valid_r <= 1'b1;
        end
      end else if (taken) begin
        out_valid_r  <= hold_valid_r;
        hold_valid_r <= 1'b0;
      end
    end
    if (mem_re) begin
      rd_bin_r <= req_bin;
      rd_oob_r <= !req_in_depth;
    end
    if (rd_pend_r) begin
      if (!out_valid_r || taken) begin
        out_bin_r <= rd_bin_r;
        out_rng_r <= ent_rng;
        out_vld_r <= ent_vld;
      end else begin
        hold_bin_r <= rd_bin_r;
        hold_rng_r <= ent_rng;
        hold_vld_r <= ent_vld;
      end
    end else if (taken && hold_valid_r) begin
      out_bin_r <= hold_bin_r;
      out_rng_r <= hold_rng_r;
      out_vld_r <= hold_vld_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_rng_r, out_bin_r};
  assign out_tuser  = out_vld_r;

  // Checks on the sequencer and result path.
  `SSO_ASSERT_NOW(a_hold_behind_out, hold_valid_r, out_valid_r,
    "hold register full while output register empty")
  `SSO_ASSERT_NEXT(a_read_lands, rd_pend_r, out_valid_r,
    "read data did not reach the output register")
  `SSO_ASSERT_NOW(a_seg_bin_in_limit, seg_we, wbin < limit,
    "segment write outside the bins in use")
  `SSO_ASSERT_NOW(a_div_done_in_div, div_rsp.done, state_r == S_DIV,
    "divider finished outside the division phase")
  `SSO_ASSERT_NOW(a_geom_done_in_geom, geom_rsp.done, state_r == S_GEOM,
    "geometry unit finished outside the geometry phase")

endmodule

>>> rtl/sso_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on sso_pkg for the request and response structs.
`timescale 1ns / 1ps

module sso_div (
  input  logic              clk,
  input  logic              rst_n,
  input  sso_pkg::div_req_t req,
  output sso_pkg::div_rsp_t rsp
);
  import sso_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0] dvd_r, dvd_nxt;
  logic [DIV_W-1:0] dvs_r, dvs_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   rem_sub;

  // One shift-and-subtract step per cycle.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    rem_sh   = {rem_r, dvd_r[DIV_W-1]};
    rem_sub  = rem_sh - {1'b0, dvs_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
      quo_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DIV_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sub[DIV_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DIV_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule

>>> rtl/sso_geom.sv
// Endpoint geometry: floor square root of x*x+z*z and CORDIC angle atan(-x/z)
// for both segment endpoints side by side. Depends on sso_pkg.
`timescale 1ns / 1ps

module sso_geom (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  sso_pkg::point_t    pts [2],
  output sso_pkg::geom_rsp_t rsp
);
  import sso_pkg::*;

  localparam logic [1:0] G_IDLE = 2'd0;
  localparam logic [1:0] G_SUM  = 2'd1;
  localparam logic [1:0] G_RUN  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [3:0] it_r, it_nxt;
  logic       done_r, done_nxt;

  logic [31:0]          xx_r   [2];
  logic [31:0]          zz_r   [2];
  logic [31:0]          rad_r  [2], rad_nxt [2];
  logic [17:0]          rem_r  [2], rem_nxt [2];
  logic [15:0]          root_r [2], root_nxt [2];
  logic signed [CX_W-1:0] cx_r [2], cx_nxt [2];
  logic signed [CX_W-1:0] cy_r [2], cy_nxt [2];
  logic signed [15:0]   ang_r  [2], ang_nxt [2];

  logic [19:0]            rem_sh [2];
  logic [19:0]            trial  [2];
  logic signed [CX_W-1:0] dx [2];
  logic signed [CX_W-1:0] dy [2];
  logic signed [15:0]     rot;

  // Sequencer: G_SUM adds the squares, then G_RUN iterates and raises done at the end.
  always_comb begin
    state_nxt = state_r;
    it_nxt    = it_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      G_IDLE: begin
        if (start) state_nxt = G_SUM;
      end
      G_SUM: begin
        state_nxt = G_RUN;
        it_nxt    = '0;
      end
      G_RUN: begin
        it_nxt = it_r + 1'b1;
        if (it_r == 4'(SQRT_STEPS - 1)) begin
          state_nxt = G_IDLE;
          done_nxt  = 1'b1;
        end
      end
      default: state_nxt = G_IDLE;
    endcase
  end

  // Per-lane datapath: in G_RUN one root digit a cycle, plus a CORDIC rotation while it_r is below CORDIC_STEPS.
  always_comb begin
    rot = $signed({3'b000, atan_lut(it_r)});
    for (int l = 0; l < 2; l++) begin
      rad_nxt[l]  = rad_r[l];
      rem_nxt[l]  = rem_r[l];
      root_nxt[l] = root_r[l];
      cx_nxt[l]   = cx_r[l];
      cy_nxt[l]   = cy_r[l];
      ang_nxt[l]  = ang_r[l];
      rem_sh[l]   = {rem_r[l], rad_r[l][31:30]};
      trial[l]    = {2'b00, root_r[l], 2'b01};
      dx[l]       = cy_r[l] >>> it_r;
      dy[l]       = cx_r[l] >>> it_r;
      if (state_r == G_SUM) begin
        rad_nxt[l]  = xx_r[l] + zz_r[l];
        rem_nxt[l]  = '0;
        root_nxt[l] = '0;
      end else if (state_r == G_RUN) begin
        rad_nxt[l] = {rad_r[l][29:0], 2'b00};
        if (rem_sh[l] >= trial[l]) begin
          rem_nxt[l]  = 18'(rem_sh[l] - trial[l]);
          root_nxt[l] = {root_r[l][14:0], 1'b1};
        end else begin
          rem_nxt[l]  = rem_sh[l][17:0];
          root_nxt[l] = {root_r[l][14:0], 1'b0};
        end
        if (it_r < 4'(CORDIC_STEPS)) begin
          if (cy_r[l] > 0) begin
            cx_nxt[l]  = cx_r[l] + dx[l];
            cy_nxt[l]  = cy_r[l] - dy[l];
            ang_nxt[l] = ang_r[l] + rot;
          end else begin
            cx_nxt[l]  = cx_r[l] - dx[l];
            cy_nxt[l]  = cy_r[l] + dy[l];
            ang_nxt[l] = ang_r[l] - rot;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_IDLE;
      it_r    <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      it_r    <= it_nxt;
      done_r  <= done_nxt;
    end
    for (int l = 0; l < 2; l++) begin
      if (state_r == G_IDLE && start) begin
        xx_r[l]  <= $signed(pts[l].x) * $signed(pts[l].x);
        zz_r[l]  <= $signed(pts[l].z) * $signed(pts[l].z);
        cx_r[l]  <= $signed({{4{pts[l].z[15]}}, pts[l].z, 8'h00});
        cy_r[l]  <= $signed(CX_W'(0)) - $signed({{4{pts[l].x[15]}}, pts[l].x, 8'h00});
        ang_r[l] <= '0;
      end else begin
        cx_r[l]  <= cx_nxt[l];
        cy_r[l]  <= cy_nxt[l];
        ang_r[l] <= ang_nxt[l];
      end
      rad_r[l]  <= rad_nxt[l];
      rem_r[l]  <= rem_nxt[l];
      root_r[l] <= root_nxt[l];
    end
  end

  assign rsp.done      = done_r;
  assign rsp.radius[0] = root_r[0];
  assign rsp.radius[1] = root_r[1];
  assign rsp.ang[0]    = ang_r[0];
  assign rsp.ang[1]    = ang_r[1];

endmodule

>>> tb/sv/scan_segment_overwrite_test.sv
// Self-checking testbench for scan_segment_overwrite: loads, segment overwrites and reads.
// Checks reads against an in-bench prediction of the range store. Depends on sso_pkg and the RTL.
`timescale 1ns / 1ps

module scan_segment_overwrite_test;
  import sso_pkg::*;

  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int PHASE_ITEMS = 270;
  localparam int NPHASE = 6;

  typedef struct {
    logic [1:0]         cmd;
    logic [9:0]         bin;
    logic [15:0]        rng;
    logic signed [15:0] sx, sz, ex, ez;
  } request_t;

  typedef struct {
    logic [9:0]  bin;
    logic [15:0] rng;
    logic        valid;
  } readback_t;

  logic        clk, rst_n;
  logic        in_tvalid, in_tready;
  logic [95:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid, out_tready;
  logic [31:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  scan_segment_overwrite dut (.*);

  // Rotation angles in radians Q2.13 for the vectoring steps.
  longint rot_angle [14] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16, 8, 4, 2, 1};

  // Per-phase register settings; phase zero runs with the reset values.
  longint phase_start [NPHASE] = '{-25736, 25736, -25736, 0, -9000, -20000};
  longint phase_step  [NPHASE] = '{29, 8192, 1, 100, 16, 45};
  longint phase_len   [NPHASE] = '{1024, 1, 1024, 700, 1024, 300};

  // Predicted block state.
  logic [16:0] range_store [1024];
  longint      cur_start, cur_step, cur_len;

  request_t  pending_requests [$];
  readback_t expected_reads [$];
  int        loaded_bins [$];
  bit        bin_loaded [1024];
  request_t  cur_req;
  bit        req_taken;
  bit        calm;
  int        in_gap, out_gap;
  int        mismatches;
  int        idle_cycles;

  // Clock: 20 ns period.
  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  function automatic longint floor_root(longint v);
    longint r;
    r = 0;
    for (int b = 16; b >= 0; b--)
      if ((r | (64'sd1 << b)) * (r | (64'sd1 << b)) <= v) r = r | (64'sd1 << b);
    return r;
  endfunction

  // Vectoring CORDIC bearing of a point, floor shifts on signed values.
  function automatic longint bearing(longint x, longint z);
    longint cx, cy, dx, dy, ang;
    cx = z * 256;
    cy = -x * 256;
    ang = 0;
    for (int i = 0; i < 14; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy > 0) begin
        cx += dx; cy -= dy; ang += rot_angle[i];
      end else begin
        cx -= dx; cy += dy; ang -= rot_angle[i];
      end
    end
    return ang;
  endfunction

  task automatic overwrite_segment(request_t r);
    longint ds, de, as_, ae, diff, count, val, bin, lim;
    if (r.sz <= 0 || r.ez <= 0 || cur_step == 0) return;
    lim = (cur_len > 1024) ? 1024 : cur_len;
    ds = floor_root(longint'(r.sx) * r.sx + longint'(r.sz) * r.sz);
    de = floor_root(longint'(r.ex) * r.ex + longint'(r.ez) * r.ez);
    as_ = bearing(r.sx, r.sz);
    ae = bearing(r.ex, r.ez);
    diff = (as_ > ae) ? as_ - ae : ae - as_;
    count = diff / cur_step;
    for (longint i = 0; i < count; i++) begin
      val = ds - ((ds - de) * i) / count;
      bin = (as_ - cur_step * i - cur_start) / cur_step;
      if (bin >= 0 && bin < lim) range_store[bin] = {1'b1, val[15:0]};
    end
  endtask

  // Applies one accepted request to the predicted store.
  task automatic predict_request(request_t r);
    readback_t e;
    case (r.cmd)
      CMD_LOAD: range_store[r.bin] = (r.rng != 0) ? {1'b1, r.rng} : 17'd0;
      CMD_SEG:  overwrite_segment(r);
      CMD_READ: begin
        e.bin = r.bin;
        e.valid = range_store[r.bin][16];
        e.rng = e.valid ? range_store[r.bin][15:0] : 16'd0;
        expected_reads.push_back(e);
      end
      default: ;
    endcase
  endtask

  function automatic request_t make_req(logic [1:0] c, int b, int rg,
                                        int sx, int sz, int ex, int ez);
    request_t r;
    r.cmd = c; r.bin = 10'(b); r.rng = 16'(rg);
    r.sx = 16'(sx); r.sz = 16'(sz); r.ex = 16'(ex); r.ez = 16'(ez);
    return r;
  endfunction

  task automatic queue_req(request_t r);
    if (r.cmd == CMD_LOAD && !bin_loaded[r.bin]) begin
      bin_loaded[r.bin] = 1;
      loaded_bins.push_back(r.bin);
    end
    pending_requests.push_back(r);
  endtask

  task automatic queue_read();
    queue_req(make_req(CMD_READ, loaded_bins[$urandom_range(0, loaded_bins.size() - 1)],
                       $urandom, 0, 0, 0, 0));
  endtask

  // Random mix; narrow segments keep bin counts bounded for fine steps.
  task automatic queue_random(int n, bit narrow_only);
    int k, sx, sz;
    for (int j = 0; j < n; j++) begin
      k = $urandom_range(0, 99);
      if (k < 35) begin
        queue_req(make_req(CMD_LOAD, $urandom_range(0, 1023),
                           ($urandom_range(0, 15) == 0) ? 0 : $urandom, 0, 0, 0, 0));
      end else if (k < 65) begin
        if (narrow_only || $urandom_range(0, 1)) begin
          sx = $urandom_range(0, 65535) - 32768;
          sz = $urandom_range(8000, 30000);
          queue_req(make_req(CMD_SEG, $urandom, $urandom, sx, sz,
                             sx + $urandom_range(0, 4000) - 2000,
                             sz + $urandom_range(0, 4000) - 2000));
        end else begin
          queue_req(make_req(CMD_SEG, $urandom, $urandom, $urandom,
                             ($urandom_range(0, 9) == 0) ? -$urandom_range(0, 32768)
                                                        : $urandom_range(1, 32767),
                             $urandom,
                             ($urandom_range(0, 9) == 0) ? -$urandom_range(0, 32768)
                                                        : $urandom_range(1, 32767)));
        end
      end else if (k < 95) begin
        queue_read();
      end else begin
        queue_req(make_req(CMD_NOP, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom));
      end
    end
  endtask

  // Waits until every request is taken and every read has come back.
  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_tvalid || expected_reads.size() != 0);
  endtask

  task automatic write_reg(logic [1:0] idx, longint v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v[15:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Request driver: new requests change at the falling edge.
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || req_taken)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        cur_req = pending_requests.pop_front();
        in_tdata <= {6'd0, cur_req.ez, cur_req.ex, cur_req.sz, cur_req.sx,
                     cur_req.rng, cur_req.bin};
        in_tuser <= cur_req.cmd;
        in_tvalid <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 16);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result backpressure in random bursts.
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 16);
    end
  end

  // Monitor: predicts accepted requests, checks results, runs the watchdog.
  always @(posedge clk) begin
    readback_t e;
    req_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      idle_cycles++;
      if (in_tvalid && in_tready) begin
        idle_cycles = 0;
        predict_request(cur_req);
      end
      if (out_tvalid && out_tready) begin
        idle_cycles = 0;
        if (expected_reads.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected read result: bin %0d range %0d valid %0d",
                     out_tdata[9:0], out_tdata[25:10], out_tuser[0]);
        end else begin
          e = expected_reads.pop_front();
          if (out_tdata[9:0] !== e.bin || out_tdata[25:10] !== e.rng
              || out_tuser[0] !== e.valid) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Read mismatch: expected bin %0d range %0d valid %0d, got %0d %0d %0d",
                       e.bin, e.rng, e.valid, out_tdata[9:0], out_tdata[25:10], out_tuser[0]);
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no request or result accepted for %0d cycles", idle_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    req_taken = 0;
    calm = 0;
    in_gap = 0;
    out_gap = 0;
    mismatches = 0;
    idle_cycles = 0;
    cur_start = -25736;
    cur_step = 29;
    cur_len = 1024;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: field extremes, zero range, segments behind the camera,
    // zero-length and reversed segments, and a no-op.
    queue_req(make_req(CMD_LOAD, 0, 1, 0, 0, 0, 0));
    queue_req(make_req(CMD_LOAD, 1023, 65535, 0, 0, 0, 0));
    queue_req(make_req(CMD_LOAD, 5, 0, 0, 0, 0, 0));
    queue_req(make_req(CMD_LOAD, 512, 16'hAAAA, 0, 0, 0, 0));
    queue_req(make_req(CMD_LOAD, 341, 16'h5555, 0, 0, 0, 0));
    queue_req(make_req(CMD_READ, 5, 0, 0, 0, 0, 0));
    queue_req(make_req(CMD_READ, 1023, 0, 0, 0, 0, 0));
    queue_req(make_req(CMD_READ, 0, 0, 0, 0, 0, 0));
    queue_req(make_req(CMD_SEG, 0, 0, 100, 0, 0, 1000));
    queue_req(make_req(CMD_SEG, 0, 0, 100, 1000, 0, -32768));
    queue_req(make_req(CMD_SEG, 0, 0, 1234, 5678, 1234, 5678));
    queue_req(make_req(CMD_SEG, 0, 0, -3000, 4000, 3000, 4000));
    queue_req(make_req(CMD_SEG, 0, 0, 3000, 4000, -3000, 4000));
    queue_req(make_req(CMD_SEG, 0, 0, -32768, 32767, 32767, 32767));
    queue_req(make_req(CMD_SEG, 0, 0, 32767, 1, -32768, 1));
    queue_req(make_req(CMD_READ, 512, 0, 0, 0, 0, 0));
    queue_req(make_req(CMD_READ, 341, 0, 0, 0, 0, 0));
    queue_req(make_req(CMD_NOP, 1023, 65535, -1, -1, -1, -1));
    queue_req(make_req(CMD_LOAD, 700, 4321, 0, 0, 0, 0));
    queue_req(make_req(CMD_READ, 0, 0, 0, 0, 0, 0));

    for (int p = 0; p < NPHASE; p++) begin
      if (p != 0) begin
        // The trailing read of the last phase proves the block has gone idle.
        wait_quiet();
        repeat (5) @(negedge clk);
        write_reg(CFG_ANGLE_START, phase_start[p]);
        write_reg(CFG_ANGLE_STEP, phase_step[p]);
        write_reg(CFG_SCAN_LENGTH, phase_len[p]);
        cur_start = phase_start[p];
        cur_step = phase_step[p];
        cur_len = phase_len[p];
      end
      if (p == NPHASE - 1) calm = 1;
      queue_random(PHASE_ITEMS, phase_step[p] < 16);
      queue_read();
    end

    wait_quiet();
    repeat (50) @(negedge clk);
    if (mismatches == 0 && expected_reads.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
